// ----- hw/rtl/grid_bfs_path_planner_assert.svh -----
// ----------------------------------------------------------------------------
// Planner assertion macros
// Concurrent assertion forms shared by the planner RTL.
// ----------------------------------------------------------------------------
`ifndef GRID_BFS_PATH_PLANNER_ASSERT_SVH
`define GRID_BFS_PATH_PLANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBPP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("planner assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GBPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("planner assertion failed");

`endif

// ----- hw/rtl/gbpp_pkg.sv -----
// ----------------------------------------------------------------------------
// Grid planner package
// Shared types, defaults and codes of the grid path planner.
// ----------------------------------------------------------------------------
package gbpp_pkg;

    localparam int GBPP_GRID_WIDTH  = 32;
    localparam int GBPP_GRID_HEIGHT = 32;
    localparam int GBPP_AGENTS      = 4;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_PLAN  = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CLR, S_SEED, S_POP, S_POPW, S_NB, S_NBW,
        S_WALK, S_WALKW, S_QRD, S_QCMP, S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] operation;
        logic [4:0] pos_x;
        logic [4:0] pos_y;
        logic [4:0] target_x;
        logic [4:0] target_y;
        logic [1:0] agent;
        logic       wall;
    } t_req;

    typedef struct packed {
        logic [4:0]  next_x;
        logic [4:0]  next_y;
        logic        found;
        logic [10:0] path_cells;
    } t_rsp;

endpackage

// ----- hw/rtl/gbpp_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request word.
// ----------------------------------------------------------------------------
interface gbpp_req_if import gbpp_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/gbpp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one response word.
// ----------------------------------------------------------------------------
interface gbpp_rsp_if import gbpp_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/grid_bfs_path_planner.sv -----
// Wall write, unused code or rejected word: the word goes to S_DONE, which loads the response into the output register.
// Plan: the visited memory is cleared, cells are dequeued and their neighbours probed, then the path is walked back.
// Query: the stored path entries are read and compared in turn until the position or the last entry is met.
// After reset a sweep clears the wall and visited memories; no word is taken then.
// A new word is taken while an earlier response still waits in the output register.
// ----------------------------------------------------------------------------
// Grid path planner
// Breadth-first flood over a wall map held in memory, with per-agent paths.
// ----------------------------------------------------------------------------
`include "grid_bfs_path_planner_assert.svh"

module grid_bfs_path_planner import gbpp_pkg::*; #(
    parameter int GRID_WIDTH  = GBPP_GRID_WIDTH,
    parameter int GRID_HEIGHT = GBPP_GRID_HEIGHT,
    parameter int AGENTS      = GBPP_AGENTS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gbpp_req_if.sink     i_req,
    gbpp_rsp_if.source   o_rsp
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int PW    = XW + YW;
    localparam int CW    = $clog2(CELLS);
    localparam int LW    = $clog2(CELLS + 1);
    localparam int AW    = (AGENTS > 1) ? $clog2(AGENTS) : 1;

    logic          wall_mem [2**PW];
    logic          vis_mem  [2**PW];
    logic [PW-1:0] par_mem  [2**PW];
    logic [PW-1:0] fifo_mem [CELLS];
    logic [PW-1:0] path_mem [AGENTS * (2**CW)];

    t_state        r_state, n_state;
    logic [PW-1:0] r_clr, n_clr;
    logic [4:0]    r_nx, n_nx, r_ny, n_ny;
    logic [AW-1:0] r_agent, n_agent;
    logic [PW-1:0] r_start, n_start, r_target, n_target;
    logic [PW-1:0] r_cur, n_cur, r_nb, n_nb, r_c, n_c, r_prev, n_prev;
    logic [1:0]    r_dir, n_dir;
    logic [LW-1:0] r_head, n_head, r_tail, n_tail, r_n, n_n, r_i, n_i;
    logic [LW-1:0] r_qlen, n_qlen, r_cells, n_cells;
    logic          r_reached, n_reached, r_found, n_found, r_ov, n_ov;
    logic [LW-1:0] r_len [AGENTS];
    logic [LW-1:0] n_len [AGENTS];
    t_rsp          r_rsp, n_rsp;

    logic          wall_we, wall_wd, vis_we, vis_wd, par_we, fifo_we, fifo_re, path_we;
    logic [PW-1:0] wall_wa, vis_wa, par_wa, par_wd, grid_ra, par_ra, fifo_wd, path_wd;
    logic [CW-1:0] fifo_wa, fifo_ra;
    logic [AW+CW-1:0] path_wa, path_ra;
    logic          r_wall_q, r_vis_q;
    logic [PW-1:0] r_par_q, r_fifo_q, r_path_q;

    logic          accept, pos_in, tgt_in, agent_ok, do_plan, do_query, nb_ok, nb_free;
    logic          walk_end, out_load;
    logic [AW-1:0] a_idx;
    logic [PW-1:0] in_pos_key, in_tgt_key, nb_key;
    logic [XW:0]   nb_x;
    logic [YW:0]   nb_y;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign pos_in      = (32'(i_req.data.pos_x) < GRID_WIDTH) &&
                         (32'(i_req.data.pos_y) < GRID_HEIGHT);
    assign tgt_in      = (32'(i_req.data.target_x) < GRID_WIDTH) &&
                         (32'(i_req.data.target_y) < GRID_HEIGHT);
    assign agent_ok    = 32'(i_req.data.agent) < AGENTS;
    assign a_idx       = AW'(i_req.data.agent);
    assign in_pos_key  = {YW'(i_req.data.pos_y), XW'(i_req.data.pos_x)};
    assign in_tgt_key  = {YW'(i_req.data.target_y), XW'(i_req.data.target_x)};
    assign do_plan     = (i_req.data.operation == OP_PLAN) && agent_ok;
    assign do_query    = (i_req.data.operation == OP_QUERY) && agent_ok && pos_in;
    assign nb_free     = !r_wall_q && !r_vis_q;
    assign walk_end    = (r_c == r_start) || (r_n + 1'b1 == LW'(CELLS));
    assign out_load    = !r_ov || o_rsp.ready;

    always_comb begin
        nb_x  = {1'b0, r_cur[XW-1:0]};
        nb_y  = {1'b0, r_cur[PW-1:XW]};
        nb_ok = 1'b1;
        case (r_dir)
            2'd0: begin
                nb_ok = (nb_y != '0);
                nb_y  = nb_y - 1'b1;
            end
            2'd1: begin
                nb_x  = nb_x + 1'b1;
                nb_ok = nb_x < (XW+1)'(GRID_WIDTH);
            end
            2'd2: begin
                nb_y  = nb_y + 1'b1;
                nb_ok = nb_y < (YW+1)'(GRID_HEIGHT);
            end
            default: begin
                nb_ok = (nb_x != '0);
                nb_x  = nb_x - 1'b1;
            end
        endcase
        nb_key = {nb_y[YW-1:0], nb_x[XW-1:0]};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:  if (r_clr == '1) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    if (do_plan && pos_in && tgt_in) begin
                        n_state = S_CLR;
                    end else if (do_query && (r_len[a_idx] > LW'(1))) begin
                        n_state = S_QRD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CLR:   if (r_clr == '1) n_state = S_SEED;
            S_SEED:  n_state = S_POP;
            S_POP: begin
                if (r_reached) begin
                    n_state = S_WALK;
                end else if (r_head == r_tail) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_POPW;
                end
            end
            S_POPW:  n_state = S_NB;
            S_NB: begin
                if (nb_ok) begin
                    n_state = S_NBW;
                end else if (r_dir == 2'd3) begin
                    n_state = S_POP;
                end
            end
            S_NBW: begin
                if ((nb_free && (r_nb == r_target)) || (r_dir == 2'd3)) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_NB;
                end
            end
            S_WALK:  n_state = walk_end ? S_DONE : S_WALKW;
            S_WALKW: n_state = S_WALK;
            S_QRD:   n_state = S_QCMP;
            S_QCMP: begin
                if ((r_path_q == r_start) || (r_i + 1'b1 == r_qlen)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_QRD;
                end
            end
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_clr = r_clr;  n_nx = r_nx;  n_ny = r_ny;  n_agent = r_agent;
        n_start = r_start;  n_target = r_target;  n_cur = r_cur;  n_nb = r_nb;
        n_c = r_c;  n_prev = r_prev;  n_dir = r_dir;  n_head = r_head;
        n_tail = r_tail;  n_n = r_n;  n_i = r_i;  n_qlen = r_qlen;
        n_cells = r_cells;  n_reached = r_reached;  n_found = r_found;
        n_len = r_len;
        n_rsp = r_rsp;
        n_ov = r_ov && !o_rsp.ready;
        wall_we = 1'b0;  wall_wa = r_clr;  wall_wd = 1'b0;
        vis_we = 1'b0;  vis_wa = r_clr;  vis_wd = 1'b0;
        par_we = 1'b0;  par_wa = r_start;  par_wd = r_start;
        fifo_we = 1'b0;  fifo_wa = r_tail[CW-1:0];  fifo_wd = r_start;
        fifo_re = 1'b0;  fifo_ra = r_head[CW-1:0];
        path_we = 1'b0;  path_wa = {r_agent, r_n[CW-1:0]};  path_wd = r_c;
        path_ra = {r_agent, r_i[CW-1:0]};
        grid_ra = nb_key;  par_ra = r_c;
        case (r_state)
            S_INIT: begin
                wall_we = 1'b1;
                vis_we  = 1'b1;
                n_clr   = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    n_nx     = i_req.data.pos_x;
                    n_ny     = i_req.data.pos_y;
                    n_agent  = a_idx;
                    n_start  = in_pos_key;
                    n_target = in_tgt_key;
                    n_found  = 1'b0;
                    n_cells  = '0;
                    n_clr    = '0;
                    n_i      = '0;
                    if (agent_ok) n_qlen = r_len[a_idx];
                    if ((i_req.data.operation == OP_WRITE) && pos_in) begin
                        wall_we = 1'b1;
                        wall_wa = in_pos_key;
                        wall_wd = i_req.data.wall;
                    end
                    if (do_plan && !(pos_in && tgt_in)) n_len[a_idx] = '0;
                end
            end
            S_CLR: begin
                vis_we = 1'b1;
                n_clr  = r_clr + 1'b1;
            end
            S_SEED: begin
                fifo_we   = 1'b1;
                fifo_wa   = '0;
                vis_we    = 1'b1;
                vis_wa    = r_start;
                vis_wd    = 1'b1;
                par_we    = 1'b1;
                n_tail    = LW'(1);
                n_head    = '0;
                n_reached = (r_start == r_target);
            end
            S_POP: begin
                n_n = '0;
                n_c = r_target;
                if (!r_reached) begin
                    if (r_head == r_tail) begin
                        n_len[r_agent] = '0;
                    end else begin
                        fifo_re = 1'b1;
                        n_head  = r_head + 1'b1;
                    end
                end
            end
            S_POPW: begin
                n_cur = r_fifo_q;
                n_dir = 2'd0;
            end
            S_NB: begin
                n_nb = nb_key;
                if (!nb_ok) n_dir = r_dir + 1'b1;
            end
            S_NBW: begin
                n_dir = r_dir + 1'b1;
                if (nb_free) begin
                    vis_we = 1'b1;
                    vis_wa = r_nb;
                    vis_wd = 1'b1;
                    par_we = 1'b1;
                    par_wa = r_nb;
                    par_wd = r_cur;
                    if (r_tail < LW'(CELLS)) begin
                        fifo_we = 1'b1;
                        fifo_wd = r_nb;
                        n_tail  = r_tail + 1'b1;
                    end
                    if (r_nb == r_target) n_reached = 1'b1;
                end
            end
            S_WALK: begin
                path_we = 1'b1;
                n_n     = r_n + 1'b1;
                if (walk_end) begin
                    n_len[r_agent] = r_n + 1'b1;
                    n_cells        = r_n + 1'b1;
                    n_found        = 1'b1;
                end
            end
            S_WALKW: n_c = r_par_q;
            S_QCMP: begin
                n_prev = r_path_q;
                n_i    = r_i + 1'b1;
                if ((r_path_q == r_start) && (r_i != '0)) begin
                    n_found = 1'b1;
                    n_nx    = 5'(r_prev[XW-1:0]);
                    n_ny    = 5'(r_prev[PW-1:XW]);
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_ov             = 1'b1;
                    n_rsp.next_x     = r_nx;
                    n_rsp.next_y     = r_ny;
                    n_rsp.found      = r_found;
                    n_rsp.path_cells = 11'(r_cells);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_clr     <= '0;
            r_ov      <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_n       <= '0;
            r_i       <= '0;
            r_reached <= 1'b0;
            for (int k = 0; k < AGENTS; k++) r_len[k] <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_ov      <= n_ov;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_n       <= n_n;
            r_i       <= n_i;
            r_reached <= n_reached;
            r_len     <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nx <= n_nx;  r_ny <= n_ny;  r_agent <= n_agent;  r_start <= n_start;
        r_target <= n_target;  r_cur <= n_cur;  r_nb <= n_nb;  r_c <= n_c;
        r_prev <= n_prev;  r_dir <= n_dir;  r_qlen <= n_qlen;  r_cells <= n_cells;
        r_found <= n_found;  r_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (wall_we) wall_mem[wall_wa] <= wall_wd;
        if (vis_we) vis_mem[vis_wa] <= vis_wd;
        if (par_we) par_mem[par_wa] <= par_wd;
        if (fifo_we) fifo_mem[fifo_wa] <= fifo_wd;
        if (path_we) path_mem[path_wa] <= path_wd;
        r_wall_q <= wall_mem[grid_ra];
        r_vis_q  <= vis_mem[grid_ra];
        r_par_q  <= par_mem[par_ra];
        if (fifo_re) r_fifo_q <= fifo_mem[fifo_ra];
        r_path_q <= path_mem[path_ra];
    end

    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_rsp;

    `GBPP_ASSERT_NOW(a_ready_idle, i_clk, i_rst_n, i_req.ready, r_state == S_IDLE)
    `GBPP_ASSERT_NOW(a_fifo_order, i_clk, i_rst_n, 1'b1,
                     (r_head <= r_tail) && (r_tail <= LW'(CELLS)))
    `GBPP_ASSERT_NEXT(a_rsp_load, i_clk, i_rst_n, (r_state == S_DONE) && out_load, r_ov)
    `GBPP_ASSERT_NOW(a_found_cells, i_clk, i_rst_n, r_ov && (r_rsp.path_cells != '0), r_rsp.found)

endmodule

// ----- verif/grid_bfs_path_planner_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planner response checker
// Watches the request and response channels, keeps its own copy of the wall
// map and the agents' paths, predicts each response and compares it.
// ----------------------------------------------------------------------------
module grid_bfs_path_planner_checker import gbpp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  t_req        i_req_data,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  t_rsp        i_rsp_data,
    output int          o_errors,
    output int          o_pending
);

    localparam int CELLS = GBPP_GRID_WIDTH * GBPP_GRID_HEIGHT;

    bit          walls [CELLS];
    bit          seen [CELLS];
    int unsigned parent [CELLS];
    int unsigned frontier [CELLS];
    int unsigned route [GBPP_AGENTS][CELLS];
    int unsigned route_len [GBPP_AGENTS];
    t_rsp        expected_rsp [$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = expected_rsp.size();

    function automatic int unsigned flood(int unsigned a, int unsigned start,
                                          int unsigned goal);
        int unsigned head, tail, n, c, cur, cx, cy, nb;
        int          nx, ny;
        bit          reached;
        head = 0;
        tail = 0;
        n = 0;
        reached = (start == goal);
        foreach (seen[i]) seen[i] = 0;
        frontier[tail++] = start;
        seen[start] = 1;
        parent[start] = start;
        while (!reached && head < tail) begin
            cur = frontier[head++];
            cx = cur % GBPP_GRID_WIDTH;
            cy = cur / GBPP_GRID_WIDTH;
            for (int d = 0; d < 4; d++) begin
                nx = cx;
                ny = cy;
                case (d)
                    0: ny = ny - 1;
                    1: nx = nx + 1;
                    2: ny = ny + 1;
                    default: nx = nx - 1;
                endcase
                if (nx < 0 || ny < 0 || nx >= GBPP_GRID_WIDTH || ny >= GBPP_GRID_HEIGHT)
                    continue;
                nb = ny * GBPP_GRID_WIDTH + nx;
                if (walls[nb] || seen[nb]) continue;
                seen[nb] = 1;
                parent[nb] = cur;
                if (tail < CELLS) frontier[tail++] = nb;
                if (nb == goal) begin
                    reached = 1;
                    break;
                end
            end
        end
        if (reached) begin
            c = goal;
            while (n < CELLS) begin
                route[a][n++] = c;
                if (c == start) break;
                c = parent[c];
            end
        end
        route_len[a] = n;
        return n;
    endfunction

    function automatic t_rsp predict_step(t_req r);
        t_rsp        p;
        int unsigned pcell, nc;
        p.next_x = r.pos_x;
        p.next_y = r.pos_y;
        p.found = 0;
        p.path_cells = 0;
        pcell = r.pos_y * GBPP_GRID_WIDTH + r.pos_x;
        if (r.operation == OP_WRITE) begin
            walls[pcell] = r.wall;
        end else if (r.operation == OP_PLAN && r.agent < GBPP_AGENTS) begin
            p.path_cells = 11'(flood(r.agent, pcell,
                                     r.target_y * GBPP_GRID_WIDTH + r.target_x));
            p.found = p.path_cells != 0;
        end else if (r.operation == OP_QUERY && r.agent < GBPP_AGENTS) begin
            if (route_len[r.agent] > 1) begin
                for (int i = 0; i < route_len[r.agent]; i++) begin
                    if (route[r.agent][i] == pcell) begin
                        if (i > 0) begin
                            nc = route[r.agent][i - 1];
                            p.next_x = 5'(nc % GBPP_GRID_WIDTH);
                            p.next_y = 5'(nc / GBPP_GRID_WIDTH);
                            p.found = 1;
                        end
                        break;
                    end
                end
            end
        end
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_rsp e;
        if (!i_rst_n) begin
            errors <= 0;
            expected_rsp.delete();
            foreach (walls[i]) walls[i] = 0;
            foreach (route_len[i]) route_len[i] = 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_rsp.size() == 0) begin
                    $display("%0t: unexpected word %p", $time, i_rsp_data);
                    errors <= errors + 1;
                end else begin
                    e = expected_rsp.pop_front();
                    if (e.next_x !== i_rsp_data.next_x || e.next_y !== i_rsp_data.next_y
                        || e.found !== i_rsp_data.found
                        || e.path_cells !== i_rsp_data.path_cells) begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, i_rsp_data);
                        errors <= errors + 1;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                expected_rsp = {expected_rsp, predict_step(i_req_data)};
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid planner testbench
// Drives wall writes, plans, queries and unused operation codes through the request
// channel under varied idling and back-pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench import gbpp_pkg::*; ();

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors, pending;
    int   send_idle = 0, recv_stall = 0;
    bit   hold_off = 0;
    int   quiet = 0;
    bit   sweeping = 0;

    gbpp_req_if req_if ();
    gbpp_rsp_if rsp_if ();

    grid_bfs_path_planner DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    grid_bfs_path_planner_checker rsp_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_if.valid),
        .i_req_ready (req_if.ready),
        .i_req_data  (req_if.data),
        .i_rsp_valid (rsp_if.valid),
        .i_rsp_ready (rsp_if.ready),
        .i_rsp_data  (rsp_if.data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        req_if.valid = 0;
        req_if.data = '0;
        rsp_if.ready = 0;
    end

    always @(posedge i_clk) begin
        rsp_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet <= 0;
        else if (!sweeping)
            quiet <= quiet + 1;
        if (quiet > 400000) begin
            $display("** grid_bfs_path_planner: FAILED **");
            $finish;
        end
    end

    task automatic send_word(t_req r);
        while ($urandom_range(99) < send_idle) begin
            req_if.valid <= 0;
            @(posedge i_clk);
        end
        req_if.valid <= 1;
        req_if.data <= r;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic send_op(t_op op, int x, int y, int tx, int ty, int a, bit w);
        t_req r;
        r.operation = op;
        r.pos_x = 5'(x);
        r.pos_y = 5'(y);
        r.target_x = 5'(tx);
        r.target_y = 5'(ty);
        r.agent = 2'(a);
        r.wall = w;
        send_word(r);
    endtask

    task automatic drain();
        req_if.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_word();
        int k, x, y;
        k = $urandom_range(99);
        x = $urandom_range(31);
        y = $urandom_range(31);
        if (k < 45)
            send_op(OP_WRITE, x, y, $urandom, $urandom, $urandom, $urandom_range(99) < 35);
        else if (k < 60)
            send_op(OP_PLAN, x, y, $urandom_range(31), $urandom_range(31), $urandom, 0);
        else if (k < 62)
            send_op(t_op'(2'd3), x, y, $urandom, $urandom, $urandom, $urandom);
        else
            send_op(OP_QUERY, x, y, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Plans a route for an agent and queries it at the start cell and the next two cells along its row.
    task automatic walk_route();
        int a, x, y, tx, ty;
        a = $urandom_range(3);
        x = $urandom_range(31);
        y = $urandom_range(31);
        tx = (x + $urandom_range(6)) % 32;
        ty = (y + $urandom_range(6)) % 32;
        send_op(OP_PLAN, x, y, tx, ty, a, 0);
        for (int i = 0; i < 3; i++)
            send_op(OP_QUERY, (x + i) % 32, y, $urandom, $urandom, a, $urandom);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        sweeping <= 1;
        repeat (GBPP_GRID_WIDTH * GBPP_GRID_HEIGHT + 10) @(posedge i_clk);
        sweeping <= 0;

        send_op(OP_PLAN, 0, 0, 0, 0, 0, 0);
        send_op(OP_QUERY, 0, 0, 0, 0, 0, 0);
        send_op(OP_PLAN, 0, 0, 31, 31, 1, 0);
        send_op(OP_QUERY, 0, 0, 0, 0, 1, 0);
        send_op(OP_QUERY, 31, 31, 0, 0, 1, 1);
        send_op(OP_QUERY, 5, 9, 0, 0, 2, 0);
        for (int i = 0; i < 3; i++) send_op(OP_WRITE, 31, 30 - i, 0, 0, 0, 1);
        send_op(OP_WRITE, 30, 31, 0, 0, 0, 1);
        send_op(OP_PLAN, 0, 0, 31, 31, 2, 0);
        send_op(OP_WRITE, 3, 3, 0, 0, 0, 1);
        send_op(OP_PLAN, 3, 3, 3, 5, 3, 1);
        send_op(OP_QUERY, 3, 4, 0, 0, 3, 0);
        send_op(OP_PLAN, 0, 0, 3, 3, 0, 0);
        send_op(t_op'(2'd3), 31, 31, 31, 31, 3, 1);
        send_op(OP_WRITE, 31, 30, 0, 0, 0, 0);
        send_op(OP_PLAN, 31, 31, 30, 31, 3, 0);
        send_op(OP_QUERY, 31, 30, 31, 31, 3, 1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 77 : 24) : 0;
            recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 77 : 24) : 0;
            if (ph == 2) begin
                hold_off = 1;
                fork
                    begin
                        repeat (3000) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < 8; n++) begin
                if ($urandom_range(1)) walk_route();
                else random_word();
            end
            drain();
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("** grid_bfs_path_planner: PASSED **");
        else
            $display("** grid_bfs_path_planner: FAILED **");
        $finish;
    end

endmodule
